/* hdl/rcpm_pkg.sv */
// package for the row/column permutation map
// shared widths, action codes and controller/datapath interface structs
// no dependencies
package rcpm_pkg;

    localparam int DEF_ROWS = 1024;
    localparam int DEF_COLS = 4096;

    localparam int ACT_W  = 2;
    localparam int IDX_W  = 13;
    localparam int VAL_W  = 23;
    localparam int DATA_W = 56;

    localparam logic [ACT_W-1:0] ACT_SWAP_ROW = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SWAP_COL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_LOCATE   = 2'd3;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_fwd;
        logic rd_second;
        logic hold_first;
        logic wr_first;
        logic wr_second;
        logic rd_inv;
        logic out_load;
    } rcpm_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             swap_ok;
        logic             qry_ok;
        logic             loc_ok;
        logic             clr_last;
        logic             out_busy;
    } rcpm_stat_t;

endpackage

/* hdl/rcpm_ram.sv */
// generic single write port, single read port ram with registered read
// depends on nothing
module rcpm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/rcpm_ctrl.sv */
// controller state machine for the row/column permutation map
// depends on rcpm_pkg for the action codes and command/status structs
module rcpm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rcpm_pkg::rcpm_stat_t stat,
    output rcpm_pkg::rcpm_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DECODE = 4'd2;
    localparam logic [3:0] ST_SW_RB  = 4'd3;
    localparam logic [3:0] ST_SW_W1  = 4'd4;
    localparam logic [3:0] ST_SW_W2  = 4'd5;
    localparam logic [3:0] ST_DV1    = 4'd6;
    localparam logic [3:0] ST_DV2    = 4'd7;
    localparam logic [3:0] ST_LC_RD  = 4'd8;
    localparam logic [3:0] ST_RESULT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.act)
                    rcpm_pkg::ACT_SWAP_ROW, rcpm_pkg::ACT_SWAP_COL:
                    begin
                        if (stat.swap_ok)
                        begin
                            cmd.rd_fwd = 1'b1;
                            state_next = ST_SW_RB;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    rcpm_pkg::ACT_QUERY:
                    begin
                        cmd.rd_fwd = stat.qry_ok;
                        state_next = ST_RESULT;
                    end
                    rcpm_pkg::ACT_LOCATE:
                    begin
                        state_next = stat.loc_ok ? ST_DV1 : ST_RESULT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SW_RB:
            begin
                cmd.rd_fwd     = 1'b1;
                cmd.rd_second  = 1'b1;
                cmd.hold_first = 1'b1;
                state_next     = ST_SW_W1;
            end
            ST_SW_W1:
            begin
                cmd.wr_first = 1'b1;
                state_next   = ST_SW_W2;
            end
            ST_SW_W2:
            begin
                cmd.wr_second = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_DV1:
            begin
                state_next = ST_DV2;
            end
            ST_DV2:
            begin
                state_next = ST_LC_RD;
            end
            ST_LC_RD:
            begin
                cmd.rd_inv = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/rcpm_dpath.sv */
// datapath for the row/column permutation map: forward and inverse map
// memories, clearing counter, reciprocal divider and result register
// depends on rcpm_pkg and rcpm_ram
module rcpm_dpath #(
    parameter int ROWS = rcpm_pkg::DEF_ROWS,
    parameter int COLS = rcpm_pkg::DEF_COLS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcpm_pkg::rcpm_cmd_t         cmd,
    output rcpm_pkg::rcpm_stat_t        stat,
    input  logic [rcpm_pkg::ACT_W-1:0]  action,
    input  logic [rcpm_pkg::IDX_W-1:0]  first_index,
    input  logic [rcpm_pkg::IDX_W-1:0]  second_index,
    input  logic [rcpm_pkg::VAL_W-1:0]  value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rcpm_pkg::VAL_W-1:0]  cell_value,
    output logic [rcpm_pkg::IDX_W-1:0]  found_row,
    output logic [rcpm_pkg::IDX_W-1:0]  found_col,
    output logic                        status
);

    localparam int IW     = rcpm_pkg::IDX_W;
    localparam int VW     = rcpm_pkg::VAL_W;
    localparam int AW     = rcpm_pkg::ACT_W;
    localparam int RA     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CA     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int MAXD   = (ROWS > COLS) ? ROWS : COLS;
    localparam int CLW    = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int CELLS  = ROWS * COLS;
    localparam int MUL_M  = (1 << VW) / COLS;
    localparam int PROD_W = 2 * VW + 1;
    localparam int QC_W   = VW + IW;
    localparam int CV_W   = 2 * IW;

    // request fields
    logic [AW-1:0] act_reg;
    logic [IW-1:0] a_reg;
    logic [IW-1:0] b_reg;
    logic [VW-1:0] v_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            a_reg   <= first_index;
            b_reg   <= second_index;
            v_reg   <= value;
        end
    end

    logic [IW-1:0] a_m1;
    logic [IW-1:0] b_m1;
    logic          a_row_ok;
    logic          b_row_ok;
    logic          a_col_ok;
    logic          b_col_ok;

    assign a_m1     = a_reg - IW'(1);
    assign b_m1     = b_reg - IW'(1);
    assign a_row_ok = (a_reg != '0) && (a_reg <= IW'(ROWS));
    assign b_row_ok = (b_reg != '0) && (b_reg <= IW'(ROWS));
    assign a_col_ok = (a_reg != '0) && (a_reg <= IW'(COLS));
    assign b_col_ok = (b_reg != '0) && (b_reg <= IW'(COLS));

    // clearing pass counter
    logic [CLW-1:0] clr_cnt_reg;
    logic [CLW-1:0] clr_cnt_next;
    logic           clr_row;
    logic           clr_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign clr_cnt_next = cmd.clr_step ? clr_cnt_reg + CLW'(1) : clr_cnt_reg;
    assign clr_row      = cmd.clr_step && ({1'b0, clr_cnt_reg} < (CLW+1)'(ROWS));
    assign clr_col      = cmd.clr_step && ({1'b0, clr_cnt_reg} < (CLW+1)'(COLS));

    // reciprocal divide of (value - 1) by COLS: estimate, back-multiply, correct
    logic [VW-1:0]     x;
    logic [PROD_W-1:0] prod_reg;
    logic [VW-1:0]     qe;
    logic [VW-1:0]     qe_reg;
    logic [VW-1:0]     qc_reg;
    logic [VW-1:0]     rem;
    logic              corr;
    logic [VW-1:0]     qfix;
    logic [VW-1:0]     rfix;
    logic [RA-1:0]     orow_reg;
    logic [CA-1:0]     ocol_reg;

    assign x    = v_reg - VW'(1);
    assign qe   = prod_reg[PROD_W-2:VW];
    assign rem  = x - qc_reg;
    assign corr = (rem >= VW'(COLS));
    assign qfix = corr ? qe_reg + VW'(1) : qe_reg;
    assign rfix = corr ? rem - VW'(COLS) : rem;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(x) * PROD_W'(MUL_M);
        qe_reg   <= qe;
        qc_reg   <= VW'(QC_W'(qe) * QC_W'(COLS));
        orow_reg <= qfix[RA-1:0];
        ocol_reg <= rfix[CA-1:0];
    end

    // map memories
    logic          row_fwd_we;
    logic [RA-1:0] row_fwd_waddr;
    logic [RA-1:0] row_fwd_wdata;
    logic [RA-1:0] row_fwd_raddr;
    logic [RA-1:0] row_fwd_rd;
    logic          row_inv_we;
    logic [RA-1:0] row_inv_waddr;
    logic [RA-1:0] row_inv_wdata;
    logic [RA-1:0] row_inv_rd;
    logic          col_fwd_we;
    logic [CA-1:0] col_fwd_waddr;
    logic [CA-1:0] col_fwd_wdata;
    logic [CA-1:0] col_fwd_raddr;
    logic [CA-1:0] col_fwd_rd;
    logic          col_inv_we;
    logic [CA-1:0] col_inv_waddr;
    logic [CA-1:0] col_inv_wdata;
    logic [CA-1:0] col_inv_rd;
    logic [RA-1:0] tmp_row_reg;
    logic [CA-1:0] tmp_col_reg;
    logic          sw_row;
    logic          sw_col;

    assign sw_row = (cmd.wr_first || cmd.wr_second) && (act_reg == rcpm_pkg::ACT_SWAP_ROW);
    assign sw_col = (cmd.wr_first || cmd.wr_second) && (act_reg == rcpm_pkg::ACT_SWAP_COL);

    always_ff @(posedge clk)
    begin
        if (cmd.hold_first)
        begin
            tmp_row_reg <= row_fwd_rd;
            tmp_col_reg <= col_fwd_rd;
        end
    end

    assign row_fwd_raddr = cmd.rd_second ? b_m1[RA-1:0] : a_m1[RA-1:0];
    assign col_fwd_raddr = (cmd.rd_second || act_reg == rcpm_pkg::ACT_QUERY)
                           ? b_m1[CA-1:0] : a_m1[CA-1:0];

    always_comb
    begin
        row_fwd_we = clr_row || sw_row;
        row_inv_we = row_fwd_we;
        col_fwd_we = clr_col || sw_col;
        col_inv_we = col_fwd_we;
        priority if (cmd.clr_step)
        begin
            row_fwd_waddr = clr_cnt_reg[RA-1:0];
            row_fwd_wdata = clr_cnt_reg[RA-1:0];
            row_inv_waddr = clr_cnt_reg[RA-1:0];
            row_inv_wdata = clr_cnt_reg[RA-1:0];
            col_fwd_waddr = clr_cnt_reg[CA-1:0];
            col_fwd_wdata = clr_cnt_reg[CA-1:0];
            col_inv_waddr = clr_cnt_reg[CA-1:0];
            col_inv_wdata = clr_cnt_reg[CA-1:0];
        end
        else if (cmd.wr_first)
        begin
            // first slot takes the entry read from the second one
            row_fwd_waddr = a_m1[RA-1:0];
            row_fwd_wdata = row_fwd_rd;
            row_inv_waddr = row_fwd_rd;
            row_inv_wdata = a_m1[RA-1:0];
            col_fwd_waddr = a_m1[CA-1:0];
            col_fwd_wdata = col_fwd_rd;
            col_inv_waddr = col_fwd_rd;
            col_inv_wdata = a_m1[CA-1:0];
        end
        else
        begin
            row_fwd_waddr = b_m1[RA-1:0];
            row_fwd_wdata = tmp_row_reg;
            row_inv_waddr = tmp_row_reg;
            row_inv_wdata = b_m1[RA-1:0];
            col_fwd_waddr = b_m1[CA-1:0];
            col_fwd_wdata = tmp_col_reg;
            col_inv_waddr = tmp_col_reg;
            col_inv_wdata = b_m1[CA-1:0];
        end
    end

    rcpm_ram #(.WIDTH(RA), .DEPTH(ROWS)) u_row_fwd (
        .clk   (clk),
        .we    (row_fwd_we),
        .waddr (row_fwd_waddr),
        .wdata (row_fwd_wdata),
        .re    (cmd.rd_fwd),
        .raddr (row_fwd_raddr),
        .rdata (row_fwd_rd)
    );

    rcpm_ram #(.WIDTH(RA), .DEPTH(ROWS)) u_row_inv (
        .clk   (clk),
        .we    (row_inv_we),
        .waddr (row_inv_waddr),
        .wdata (row_inv_wdata),
        .re    (cmd.rd_inv),
        .raddr (orow_reg),
        .rdata (row_inv_rd)
    );

    rcpm_ram #(.WIDTH(CA), .DEPTH(COLS)) u_col_fwd (
        .clk   (clk),
        .we    (col_fwd_we),
        .waddr (col_fwd_waddr),
        .wdata (col_fwd_wdata),
        .re    (cmd.rd_fwd),
        .raddr (col_fwd_raddr),
        .rdata (col_fwd_rd)
    );

    rcpm_ram #(.WIDTH(CA), .DEPTH(COLS)) u_col_inv (
        .clk   (clk),
        .we    (col_inv_we),
        .waddr (col_inv_waddr),
        .wdata (col_inv_wdata),
        .re    (cmd.rd_inv),
        .raddr (ocol_reg),
        .rdata (col_inv_rd)
    );

    // result register
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [VW-1:0]   cell_reg;
    logic [IW-1:0]   frow_reg;
    logic [IW-1:0]   fcol_reg;
    logic            status_reg;
    logic [CV_W-1:0] cell_full;
    logic            res_err;
    logic [VW-1:0]   cell_next;
    logic [IW-1:0]   frow_next;
    logic [IW-1:0]   fcol_next;

    assign cell_full = CV_W'(row_fwd_rd) * CV_W'(COLS) + CV_W'(col_fwd_rd) + CV_W'(1);
    assign res_err   = (act_reg == rcpm_pkg::ACT_QUERY) ? !(a_row_ok && b_col_ok)
                                                         : !stat.loc_ok;

    always_comb
    begin
        cell_next = '0;
        frow_next = '0;
        fcol_next = '0;
        if (!res_err)
        begin
            if (act_reg == rcpm_pkg::ACT_QUERY)
            begin
                cell_next = cell_full[VW-1:0];
            end
            else
            begin
                frow_next = IW'(row_inv_rd) + IW'(1);
                fcol_next = IW'(col_inv_rd) + IW'(1);
            end
        end
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cell_reg   <= cell_next;
            frow_reg   <= frow_next;
            fcol_reg   <= fcol_next;
            status_reg <= res_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_reg;
    assign found_row  = frow_reg;
    assign found_col  = fcol_reg;
    assign status     = status_reg;

    // status back to the controller
    assign stat.act      = act_reg;
    assign stat.swap_ok  = (act_reg == rcpm_pkg::ACT_SWAP_ROW) ? (a_row_ok && b_row_ok)
                                                                : (a_col_ok && b_col_ok);
    assign stat.qry_ok   = a_row_ok && b_col_ok;
    assign stat.loc_ok   = (v_reg != '0) && ({2'b00, v_reg} <= (VW+2)'(CELLS));
    assign stat.clr_last = (clr_cnt_reg == CLW'(MAXD - 1));
    assign stat.out_busy = out_valid_reg && !out_ready;

endmodule

/* hdl/row_column_permutation_map.sv */
// top level of the row/column permutation map
// depends on rcpm_pkg, rcpm_ctrl, rcpm_dpath (which holds the rcpm_ram instances)
//
// Tracks a ROWS x COLS matrix whose cell at 1-based (r, c) starts out as
// (r-1)*COLS + c, through a row permutation and a column permutation. Each
// permutation is held twice, forward (current position to original) and
// inverse (original to current position), in single-port-read memories, so a
// locate is a couple of lookups rather than a search. After reset a clearing
// pass writes identity into all four memories, during which no request is
// taken. Each request then occupies the block until the controller is back
// in idle, so no new request is taken before then: a swap makes two reads and
// two writes through the one read and one write port of each map memory, a
// query one read of each forward map, then one multiply-add, and a locate a
// reciprocal multiply, a back-multiply with one correction for the divide by
// COLS, then one read of each inverse map. Swaps produce nothing; queries and
// locates produce one result. A result waiting in the output register does
// not stop the next request from being taken, only the loading of the
// following result. An index or value out of range changes nothing, and for
// a query or locate it sets status.
module row_column_permutation_map #(
    parameter int ROWS = rcpm_pkg::DEF_ROWS,
    parameter int COLS = rcpm_pkg::DEF_COLS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [12:0] first_index, [25:13] second_index, [48:26] value, [55:49] zero
    input  logic [rcpm_pkg::DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [rcpm_pkg::ACT_W-1:0]   s_axis_tuser,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [22:0] cell_value, [35:23] found_row, [48:36] found_col, [55:49] zero
    output logic [rcpm_pkg::DATA_W-1:0]  m_axis_tdata,
    // [0] status
    output logic [0:0]                   m_axis_tuser
);

    localparam int IW = rcpm_pkg::IDX_W;
    localparam int VW = rcpm_pkg::VAL_W;
    localparam int PAD_W = rcpm_pkg::DATA_W - VW - 2 * IW;

    rcpm_pkg::rcpm_cmd_t  cmd;
    rcpm_pkg::rcpm_stat_t stat;

    logic [VW-1:0] cell_value;
    logic [IW-1:0] found_row;
    logic [IW-1:0] found_col;
    logic          status;

    // sequencing of each request
    rcpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // maps, divider and result register
    rcpm_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (s_axis_tuser),
        .first_index  (s_axis_tdata[IW-1:0]),
        .second_index (s_axis_tdata[2*IW-1:IW]),
        .value        (s_axis_tdata[2*IW+VW-1:2*IW]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .cell_value   (cell_value),
        .found_row    (found_row),
        .found_col    (found_col),
        .status       (status)
    );

    // pack the result fields, lowest first
    assign m_axis_tdata = {{PAD_W{1'b0}}, found_col, found_row, cell_value};
    assign m_axis_tuser = status;

endmodule

/* tb/row_column_permutation_map_test.sv */
// testbench for row_column_permutation_map: row and column swaps, cell queries and locates
// depends on rcpm_pkg and the row_column_permutation_map rtl; checks against its own layout model
`timescale 1ns / 1ps

module row_column_permutation_map_test;

    localparam int ACT_W  = rcpm_pkg::ACT_W;
    localparam int IDX_W  = rcpm_pkg::IDX_W;
    localparam int VAL_W  = rcpm_pkg::VAL_W;
    localparam int DATA_W = rcpm_pkg::DATA_W;

    localparam int ROWS          = rcpm_pkg::DEF_ROWS;
    localparam int COLS          = rcpm_pkg::DEF_COLS;
    localparam int VALUE_MAX     = ROWS * COLS;
    localparam int RESET_CYCLES  = 7;
    // longest request is a locate, leave a good margin after the last result
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 500;
    // covers the clearing pass plus ~1500 requests
    localparam longint TIMEOUT_NS = 64'd12 * 64'd600000;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // one result as it leaves the block
    typedef struct packed {
        logic [VAL_W-1:0] cell_value;
        logic [IDX_W-1:0] found_row;
        logic [IDX_W-1:0] found_col;
        logic             status;
    } map_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;
    logic [ACT_W-1:0]  s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    // current layout: original row / column now sitting at each 0-based position
    logic [IDX_W-1:0]  row_origin [ROWS];
    logic [IDX_W-1:0]  col_origin [COLS];

    // results still owed by the block, oldest first
    map_result_t       awaited_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int results_checked;
    int swap_requests;
    int query_requests;
    int locate_requests;
    int range_flagged;

    row_column_permutation_map #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // apply one accepted request to the layout and queue the result it owes
    function automatic void predict_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] first,
                                            logic [IDX_W-1:0] second, logic [VAL_W-1:0] val);
        map_result_t      res;
        logic [IDX_W-1:0] held;
        int               orig_row;
        int               orig_col;
        res        = '0;
        res.status = STATUS_OK;
        case (act)
            rcpm_pkg::ACT_SWAP_ROW:
            begin
                swap_requests++;
                // a bad index on either side leaves the layout alone
                if (first >= 1 && first <= ROWS && second >= 1 && second <= ROWS)
                begin
                    held                 = row_origin[first-1];
                    row_origin[first-1]  = row_origin[second-1];
                    row_origin[second-1] = held;
                end
            end
            rcpm_pkg::ACT_SWAP_COL:
            begin
                swap_requests++;
                if (first >= 1 && first <= COLS && second >= 1 && second <= COLS)
                begin
                    held                 = col_origin[first-1];
                    col_origin[first-1]  = col_origin[second-1];
                    col_origin[second-1] = held;
                end
            end
            rcpm_pkg::ACT_QUERY:
            begin
                query_requests++;
                if (first < 1 || first > ROWS || second < 1 || second > COLS)
                begin
                    res.status = STATUS_RANGE;
                    range_flagged++;
                end
                else
                begin
                    res.cell_value = VAL_W'(longint'(row_origin[first-1]) * COLS
                                            + longint'(col_origin[second-1]) + 1);
                end
                awaited_results.push_back(res);
            end
            default:
            begin
                locate_requests++;
                if (val == 0 || val > VALUE_MAX)
                begin
                    res.status = STATUS_RANGE;
                    range_flagged++;
                end
                else
                begin
                    // split the value into its original row and column, then search
                    orig_row = (int'(val) - 1) / COLS;
                    orig_col = (int'(val) - 1) % COLS;
                    for (int i = 0; i < ROWS; i++)
                        if (res.found_row == 0 && row_origin[i] == orig_row)
                            res.found_row = IDX_W'(i + 1);
                    for (int i = 0; i < COLS; i++)
                        if (res.found_col == 0 && col_origin[i] == orig_col)
                            res.found_col = IDX_W'(i + 1);
                end
                awaited_results.push_back(res);
            end
        endcase
    endfunction

    // compare one result with the oldest one owed
    task automatic check_result(logic [DATA_W-1:0] data, logic [0:0] flags);
        map_result_t got;
        map_result_t want;
        got.cell_value = data[22:0];
        got.found_row  = data[35:23];
        got.found_col  = data[48:36];
        got.status     = flags[0];
        results_checked++;
        if (awaited_results.size() == 0)
        begin
            $error("unexpected result: cell_value %0d found_row %0d found_col %0d status %0d",
                   got.cell_value, got.found_row, got.found_col, got.status);
            fail_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.cell_value !== want.cell_value)
            begin
                $error("cell_value mismatch: expected %0d, actual %0d",
                       want.cell_value, got.cell_value);
                fail_count++;
            end
            if (got.found_row !== want.found_row)
            begin
                $error("found_row mismatch: expected %0d, actual %0d",
                       want.found_row, got.found_row);
                fail_count++;
            end
            if (got.found_col !== want.found_col)
            begin
                $error("found_col mismatch: expected %0d, actual %0d",
                       want.found_col, got.found_col);
                fail_count++;
            end
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
        end
    endtask

    // results are taken at the rising edge where both valid and ready were high
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata, m_axis_tuser);
    end

    // present one request, hold it until the block takes it, then predict
    task automatic send_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] first,
                                logic [IDX_W-1:0] second, logic [VAL_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {7'd0, val, second, first};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(act, first, second, val);
    endtask

    // sender holds off until every owed result is back
    task automatic pause_until_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // index biased to a small hot corner and the top edge, with some raw noise
    function automatic logic [IDX_W-1:0] pick_index(int limit);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return IDX_W'($urandom_range(8191));
        if (r < 35)
            return IDX_W'($urandom_range(1, 8));
        if (r < 45)
            return IDX_W'(limit - $urandom_range(0, 3));
        return IDX_W'($urandom_range(1, limit));
    endfunction

    // value biased to cells of the hot corner so locates follow the swaps
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return VAL_W'($urandom);
        if (r < 40)
            return VAL_W'(($urandom_range(1, 8) - 1) * COLS + $urandom_range(1, 8));
        if (r < 48)
            return VAL_W'(VALUE_MAX - $urandom_range(0, 3));
        return VAL_W'($urandom_range(1, VALUE_MAX));
    endfunction

    task automatic send_random_request();
        logic [ACT_W-1:0] act;
        act = ACT_W'($urandom_range(3));
        case (act)
            rcpm_pkg::ACT_SWAP_ROW:
                send_request(act, pick_index(ROWS), pick_index(ROWS), VAL_W'($urandom));
            rcpm_pkg::ACT_SWAP_COL:
                send_request(act, pick_index(COLS), pick_index(COLS), VAL_W'($urandom));
            rcpm_pkg::ACT_QUERY:
                send_request(act, pick_index(ROWS), pick_index(COLS), VAL_W'($urandom));
            default:
                send_request(act, IDX_W'($urandom), IDX_W'($urandom), pick_value());
        endcase
    endtask

    // single reset at the start; the block then runs its clearing pass on its own
    task automatic run_reset();
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    endtask

    // corners, every action, every range flag, self swap and bad swaps
    task automatic test_directed_edges();
        send_idle_pct = 16;
        recv_idle_pct = 76;
        send_request(rcpm_pkg::ACT_QUERY, 13'd1, 13'd1, 23'd0);
        send_request(rcpm_pkg::ACT_QUERY, IDX_W'(ROWS), IDX_W'(COLS), 23'h7FFFFF);
        send_request(rcpm_pkg::ACT_QUERY, 13'd0, 13'd1, 23'd0);
        send_request(rcpm_pkg::ACT_QUERY, IDX_W'(ROWS + 1), 13'd1, 23'd0);
        send_request(rcpm_pkg::ACT_QUERY, 13'd1, 13'd0, 23'd0);
        send_request(rcpm_pkg::ACT_QUERY, 13'd1, IDX_W'(COLS + 1), 23'd0);
        send_request(rcpm_pkg::ACT_QUERY, 13'h1FFF, 13'h1FFF, 23'd0);
        send_request(rcpm_pkg::ACT_LOCATE, 13'd0, 13'd0, 23'd1);
        send_request(rcpm_pkg::ACT_LOCATE, 13'h1FFF, 13'h1FFF, VAL_W'(VALUE_MAX));
        send_request(rcpm_pkg::ACT_LOCATE, 13'd0, 13'd0, 23'd0);
        send_request(rcpm_pkg::ACT_LOCATE, 13'd0, 13'd0, VAL_W'(VALUE_MAX + 1));
        send_request(rcpm_pkg::ACT_LOCATE, 13'd0, 13'd0, 23'h7FFFFF);
        // move the extreme rows and columns, then look again
        send_request(rcpm_pkg::ACT_SWAP_ROW, 13'd1, IDX_W'(ROWS), 23'd0);
        send_request(rcpm_pkg::ACT_SWAP_COL, 13'd1, IDX_W'(COLS), 23'h7FFFFF);
        send_request(rcpm_pkg::ACT_SWAP_ROW, 13'd5, 13'd5, 23'd0);
        send_request(rcpm_pkg::ACT_SWAP_COL, 13'd7, 13'd7, 23'd0);
        // out of range swaps must change nothing
        send_request(rcpm_pkg::ACT_SWAP_ROW, 13'd0, 13'd2, 23'd0);
        send_request(rcpm_pkg::ACT_SWAP_ROW, 13'd2, IDX_W'(ROWS + 1), 23'd0);
        send_request(rcpm_pkg::ACT_SWAP_COL, IDX_W'(COLS + 1), 13'd1, 23'd0);
        send_request(rcpm_pkg::ACT_SWAP_COL, 13'd3, 13'h1FFF, 23'd0);
        send_request(rcpm_pkg::ACT_QUERY, 13'd1, 13'd1, 23'd0);
        send_request(rcpm_pkg::ACT_QUERY, IDX_W'(ROWS), IDX_W'(COLS), 23'd0);
        send_request(rcpm_pkg::ACT_LOCATE, 13'd0, 13'd0, 23'd1);
        send_request(rcpm_pkg::ACT_LOCATE, 13'd0, 13'd0, VAL_W'(VALUE_MAX));
        pause_until_drained();
    endtask

    // random traffic under one idling mix, then a full drain
    task automatic test_random_mix(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_request();
        pause_until_drained();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = rcpm_pkg::ACT_SWAP_ROW;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fail_count      = 0;
        results_checked = 0;
        swap_requests   = 0;
        query_requests  = 0;
        locate_requests = 0;
        range_flagged   = 0;
        for (int i = 0; i < ROWS; i++)
            row_origin[i] = IDX_W'(i);
        for (int i = 0; i < COLS; i++)
            col_origin[i] = IDX_W'(i);

        run_reset();
        test_directed_edges();
        // slow receiver, then slow sender, then both flat out
        test_random_mix(16, 76);
        test_random_mix(76, 16);
        test_random_mix(0, 0);

        // let any stray result show up before closing
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("summary: %0d swaps, %0d queries, %0d locates, %0d flagged out of range",
                 swap_requests, query_requests, locate_requests, range_flagged);
        $display("summary: %0d results checked, %0d failures", results_checked, fail_count);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog for a block that stops answering
    initial
    begin
        #(TIMEOUT_NS * 1ns);
        $display("status: fail");
        $finish;
    end

endmodule
